// File: design/assert_macros.svh
// Assertion macros shared by the encoder modules.
// Included by every file that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

// File: design/u16enc_pkg.sv
// Types and constants of the UTF-16 to charset encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u16enc_pkg;

  localparam logic [1:0] MODE_UTF8   = 2'd0;
  localparam logic [1:0] MODE_ASCII  = 2'd1;
  localparam logic [1:0] MODE_LATIN1 = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNMAPPABLE  = 2'd1;
  localparam logic [1:0] ST_BAD_SURR    = 2'd2;

  localparam logic [15:0] ASCII_MAX  = 16'd127;
  localparam logic [15:0] LATIN1_MAX = 16'd255;

  // One encoded character: up to four bytes, byte 0 goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;  // index of the final byte
    logic [1:0]      status;
    logic            str_last;  // final byte also ends the string
  } job_t;

endpackage

// File: design/u16enc_front.sv
// Front end: takes code units, tracks surrogate and error state, builds byte jobs.
// Depends on u16enc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module u16enc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  logic             accept,
  input  logic [15:0]      code_unit,
  input  logic             last_unit,
  output logic             push,
  output u16enc_pkg::job_t job
);
  import u16enc_pkg::*;

  logic [1:0]  charset_mode;
  logic [9:0]  high_half;
  logic        half_pending;
  logic        error_seen;

  logic        utf;
  logic        is_hi;
  logic        is_lo;
  logic        hold_high;
  logic        pair_done;
  logic [1:0]  st;
  logic [20:0] cp;

  assign utf   = (charset_mode != MODE_ASCII) && (charset_mode != MODE_LATIN1);
  assign is_hi = (code_unit[15:10] == 6'b110110);
  assign is_lo = (code_unit[15:10] == 6'b110111);
  assign cp    = {1'b0, high_half, code_unit[9:0]} + 21'h10000;

  always_comb begin
    st        = ST_OK;
    hold_high = 1'b0;
    pair_done = 1'b0;
    job       = '0;
    if (half_pending && !utf) begin
      st = ST_BAD_SURR;
    end else if (utf) begin
      if (half_pending) begin
        if (is_lo) begin
          pair_done    = 1'b1;
          job.bytes[0] = {5'b11110, cp[20:18]};
          job.bytes[1] = {2'b10, cp[17:12]};
          job.bytes[2] = {2'b10, cp[11:6]};
          job.bytes[3] = {2'b10, cp[5:0]};
          job.last_idx = 2'd3;
        end else begin
          st = ST_BAD_SURR;
        end
      end else if (is_hi) begin
        if (last_unit) st = ST_BAD_SURR;
        else           hold_high = 1'b1;
      end else if (is_lo) begin
        st = ST_BAD_SURR;
      end else if (code_unit < 16'h0080) begin
        job.bytes[0] = code_unit[7:0];
        job.last_idx = 2'd0;
      end else if (code_unit < 16'h0800) begin
        job.bytes[0] = {3'b110, code_unit[10:6]};
        job.bytes[1] = {2'b10, code_unit[5:0]};
        job.last_idx = 2'd1;
      end else begin
        job.bytes[0] = {4'b1110, code_unit[15:12]};
        job.bytes[1] = {2'b10, code_unit[11:6]};
        job.bytes[2] = {2'b10, code_unit[5:0]};
        job.last_idx = 2'd2;
      end
    end else if (charset_mode == MODE_ASCII) begin
      if (code_unit > ASCII_MAX) st = ST_UNMAPPABLE;
      else                       job.bytes[0] = code_unit[7:0];
    end else begin
      if (code_unit > LATIN1_MAX) st = ST_UNMAPPABLE;
      else                        job.bytes[0] = code_unit[7:0];
    end

    if (st != ST_OK) begin
      job          = '0;
      job.status   = st;
      job.str_last = 1'b1;
    end else begin
      job.status   = ST_OK;
      job.str_last = last_unit;
    end
  end

  assign push = accept && !error_seen && !hold_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_mode <= MODE_UTF8;
      high_half    <= '0;
      half_pending <= 1'b0;
      error_seen   <= 1'b0;
    end else begin
      if (cfg_wr_en) charset_mode <= cfg_wr_data;
      if (accept) begin
        if (error_seen) begin
          if (last_unit) error_seen <= 1'b0;
        end else if (st != ST_OK) begin
          half_pending <= 1'b0;
          high_half    <= '0;
          error_seen   <= !last_unit;
        end else if (hold_high) begin
          high_half    <= code_unit[9:0];
          half_pending <= 1'b1;
        end else if (pair_done) begin
          half_pending <= 1'b0;
        end
      end
    end
  end

  `ASSERT_CHK(a_no_push_swallowed, clk, rst,
    accept && error_seen |-> !push, "front pushed a job while swallowing a string")
  `ASSERT_CHK(a_err_after_mode, clk, rst,
    push && half_pending && !utf |-> job.status == ST_BAD_SURR,
    "pending high half in a byte mode did not give a surrogate error")

endmodule

// File: design/u16enc_fifo.sv
// Short job queue between the front and back ends.
// Depends on u16enc_pkg for the job type and on assert_macros.svh.
`include "assert_macros.svh"
module u16enc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u16enc_pkg::job_t wr_job,
  input  logic             pop,
  output u16enc_pkg::job_t rd_job,
  output logic             full,
  output logic             not_empty
);
  import u16enc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ASSERT_CHK(a_no_overflow, clk, rst, push |-> !full, "job queue written while full")
  `ASSERT_CHK(a_no_underflow, clk, rst, pop |-> not_empty, "job queue read while empty")
  `ASSERT_ALL(a_count_bound, clk, rst || count <= CNT_FULL, "job queue count beyond depth")

endmodule

// File: design/u16enc_back.sv
// Back end: walks the bytes of each queued job into the output register.
// Depends on u16enc_pkg for the job type and status codes, and on assert_macros.svh.
`include "assert_macros.svh"
module u16enc_back (
  input  logic             clk,
  input  logic             rst,
  input  u16enc_pkg::job_t job,
  input  logic             job_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);
  import u16enc_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = job_valid && (!m_tvalid || m_tready);
  assign final_byte = (idx == job.last_idx);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= final_byte ? 2'd0 : idx + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= job.bytes[idx];
      m_tuser <= {final_byte, job.status};
      m_tlast <= final_byte && job.str_last;
    end
  end

  `ASSERT_CHK(a_err_shape, clk, rst,
    m_tvalid && m_tuser[1:0] != ST_OK |-> m_tdata == 8'd0 && m_tuser[2] && m_tlast,
    "error result is not a single zero byte that ends the string")
  `ASSERT_CHK(a_done_ends_run, clk, rst, m_tvalid && m_tlast |-> m_tuser[2],
    "string end flagged on a byte that does not end its character")

endmodule

// File: design/utf16_to_charset_encoder.sv
// UTF-16 to charset encoder, top level.
// Ties together u16enc_front, u16enc_fifo and u16enc_back; uses u16enc_pkg.
//   The slave stream carries one UTF-16 code unit per transaction in s_tdata,
//   with s_tlast on the final unit of a string. The master stream carries one
//   encoded byte per transaction in m_tdata; m_tuser[1:0] is the status
//   (ok, not mappable, invalid surrogate), m_tuser[2] marks the final byte of
//   a code unit, and m_tlast marks the final byte of the whole string.
//   An error result is one zero byte with both markers set; the consumer drops
//   what it already received for that string, and the rest of the string is
//   swallowed without output.
//   cfg_wr_en/cfg_wr_data write the charset (UTF-8, ASCII, Latin-1; the spare
//   code means UTF-8) and are meant to be used only while the block is idle.
//   The first byte of a unit is registered in the job queue, then in the
//   output register. The output emits one byte per cycle while the receiver
//   is ready; a unit that makes a job gives one to four bytes (three for most
//   BMP text outside ASCII), a high surrogate waiting for its partner none.
//   Units are accepted every cycle while the job queue between front and
//   back has room. When the receiver stalls, the output register holds its
//   byte, the queue fills and s_tready drops. Reset empties the queue and
//   output register, clears the surrogate and error state, and selects UTF-8.
module utf16_to_charset_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // charset_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [15:0] code_unit
  input  logic        s_tlast,       // last_unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // [7:0] out_byte
  output logic [2:0]  m_tuser,       // [1:0] status, [2] last_of_run
  output logic        m_tlast        // string_done
);
  import u16enc_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  job_t wr_job;
  job_t rd_job;

  // The front only needs queue room; a unit that makes no job still takes
  // a slot's worth of readiness, which keeps the handshake simple.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  u16enc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .code_unit   (s_tdata),
    .last_unit   (s_tlast),
    .push        (push),
    .job         (wr_job)
  );

  u16enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (wr_job),
    .pop       (pop),
    .rd_job    (rd_job),
    .full      (full),
    .not_empty (not_empty)
  );

  u16enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .job_valid (not_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: verif/utf16_to_charset_encoder_tb.sv
// Self-checking testbench for utf16_to_charset_encoder: directed and random UTF-16
// strings in every charset, with bytes predicted in the bench and compared on output.
// Depends on u16enc_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module utf16_to_charset_encoder_tb;
  import u16enc_pkg::*;

  // The spare charset code selects UTF-8, like MODE_UTF8.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  // Cycles to let pass after the last expected byte before touching the
  // charset register; a unit that only stores a high half gives no byte.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int RANDOM_UNITS  = 500;
  localparam int PHASE_UNITS   = 100;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } unit_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       run_end;
    logic       str_end;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = MODE_UTF8;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;        // [15:0] code_unit
  logic        s_tlast = 1'b0;      // last_unit
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;             // [7:0] out_byte
  logic [2:0]  m_tuser;             // [1:0] status, [2] last_of_run
  logic        m_tlast;             // string_done

  utf16_to_charset_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always #6 clk = ~clk;

  // Code units waiting to be offered, and bytes the encoder still owes us.
  unit_t     unit_q[$];
  enc_byte_t expected_bytes[$];
  int        queued_units = 0;
  int        fail_count = 0;

  // Mirror of the encoder state, updated at every accepted transaction and charset write.
  logic [1:0] charset = MODE_UTF8;
  logic [9:0] pend_high = '0;
  logic       pend_valid = 1'b0;
  logic       swallowing = 1'b0;

  // Idle pacing for both sides. A calm stretch is a run of transactions
  // with no gap at all, so back-to-back traffic gets exercised as well.
  int calm_tx = 0;
  int calm_rx = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int byte_count = 0;
  unit_t next_unit;

  task automatic draw_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r < 2) begin
      calm = $urandom_range(30, 80);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 60);
    end
  endtask

  function automatic logic is_high(input logic [15:0] cu);
    return cu >= HIGH_FIRST && cu <= HIGH_LAST;
  endfunction

  function automatic logic is_low(input logic [15:0] cu);
    return cu >= LOW_FIRST && cu <= LOW_LAST;
  endfunction

  // Works out the bytes one accepted code unit produces and queues them.
  task automatic encode_unit(input logic [15:0] cu, input logic lst);
    logic [20:0] cp;
    logic [1:0]  err;
    logic [7:0]  seq[$];
    logic        utf;
    enc_byte_t   eb;
    utf = (charset == MODE_UTF8) || (charset == MODE_SPARE);
    err = ST_OK;
    if (swallowing) begin
      // The rest of a failed string gives nothing; its last unit re-arms us.
      if (lst)
        swallowing = 1'b0;
      return;
    end
    if (pend_valid && !utf) begin
      // A high half left over from UTF-8 mode cannot be paired here.
      err = ST_BAD_SURR;
    end else if (utf) begin
      if (pend_valid) begin
        if (is_low(cu)) begin
          cp = 21'h10000 + {1'b0, pend_high, cu[9:0]};
          pend_valid = 1'b0;
          seq.insert(seq.size(), 8'hF0 | {5'd0, cp[20:18]});
          seq.insert(seq.size(), 8'h80 | {2'd0, cp[17:12]});
          seq.insert(seq.size(), 8'h80 | {2'd0, cp[11:6]});
          seq.insert(seq.size(), 8'h80 | {2'd0, cp[5:0]});
        end else begin
          err = ST_BAD_SURR;
        end
      end else if (is_high(cu)) begin
        if (lst) begin
          err = ST_BAD_SURR;
        end else begin
          // Store the high half and wait for its partner; no byte yet.
          pend_high = cu[9:0];
          pend_valid = 1'b1;
          return;
        end
      end else if (is_low(cu)) begin
        err = ST_BAD_SURR;
      end else if (cu < 16'h0080) begin
        seq.insert(seq.size(), cu[7:0]);
      end else if (cu < 16'h0800) begin
        seq.insert(seq.size(), 8'hC0 | {3'd0, cu[10:6]});
        seq.insert(seq.size(), 8'h80 | {2'd0, cu[5:0]});
      end else begin
        seq.insert(seq.size(), 8'hE0 | {4'd0, cu[15:12]});
        seq.insert(seq.size(), 8'h80 | {2'd0, cu[11:6]});
        seq.insert(seq.size(), 8'h80 | {2'd0, cu[5:0]});
      end
    end else if (charset == MODE_ASCII) begin
      if (cu > ASCII_MAX)
        err = ST_UNMAPPABLE;
      else
        seq.insert(seq.size(), cu[7:0]);
    end else begin
      if (cu > LATIN1_MAX)
        err = ST_UNMAPPABLE;
      else
        seq.insert(seq.size(), cu[7:0]);
    end

    if (err != ST_OK) begin
      // One zero byte ends the string; anything pending is dropped.
      eb.data = 8'h00;
      eb.status = err;
      eb.run_end = 1'b1;
      eb.str_end = 1'b1;
      expected_bytes.insert(expected_bytes.size(), eb);
      pend_valid = 1'b0;
      pend_high = '0;
      swallowing = !lst;
      return;
    end
    foreach (seq[i]) begin
      eb.data = seq[i];
      eb.status = ST_OK;
      eb.run_end = (i == seq.size() - 1);
      eb.str_end = (i == seq.size() - 1) && lst;
      expected_bytes.insert(expected_bytes.size(), eb);
    end
  endtask

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // Driver: offers the queued code units, pausing at random between them.
  // The prediction runs at the edge where a transaction is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (s_tvalid && s_tready)
        encode_unit(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (unit_q.size() != 0) begin
          next_unit = unit_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_unit.code;
          s_tlast <= next_unit.last;
          draw_gap(calm_tx, tx_wait);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transaction against the oldest expected
  // byte and throttles m_tready. Now and then it holds off for a long
  // stretch so that the internal queue fills and s_tready drops.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t ns: output transaction with nothing expected, actual data %0h",
                     $time, m_tdata);
        end else begin
          if (m_tdata !== expected_bytes[0].data)
            report_field("out_byte", expected_bytes[0].data, m_tdata);
          if (m_tuser[1:0] !== expected_bytes[0].status)
            report_field("status", {6'd0, expected_bytes[0].status}, {6'd0, m_tuser[1:0]});
          if (m_tuser[2] !== expected_bytes[0].run_end)
            report_field("last_of_run", {7'd0, expected_bytes[0].run_end}, {7'd0, m_tuser[2]});
          if (m_tlast !== expected_bytes[0].str_end)
            report_field("string_done", {7'd0, expected_bytes[0].str_end}, {7'd0, m_tlast});
          void'(expected_bytes.pop_front());
        end
        byte_count++;
        if (byte_count % 256 == 100)
          rx_wait = LONG_HOLD;
        else
          draw_gap(calm_rx, rx_wait);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_unit(input logic [15:0] cu, input logic lst);
    unit_t u;
    u.code = cu;
    u.last = lst;
    unit_q.insert(unit_q.size(), u);
    queued_units++;
  endtask

  // One random character for the given charset; mostly valid text with
  // some arbitrary code units mixed in.
  task automatic add_char(input logic [1:0] mode, input logic fin);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_ASCII) begin
      if (r < 85)
        add_unit(16'($urandom_range(0, 127)), fin);
      else
        add_unit(16'($urandom_range(0, 65535)), fin);
    end else if (mode == MODE_LATIN1) begin
      if (r < 85)
        add_unit(16'($urandom_range(0, 255)), fin);
      else
        add_unit(16'($urandom_range(0, 65535)), fin);
    end else if (r < 30) begin
      add_unit(16'($urandom_range(0, 16'h7F)), fin);
    end else if (r < 50) begin
      add_unit(16'($urandom_range(16'h80, 16'h7FF)), fin);
    end else if (r < 60) begin
      add_unit(16'($urandom_range(16'h800, 16'hD7FF)), fin);
    end else if (r < 70) begin
      add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), fin);
    end else if (r < 88) begin
      add_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
      add_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), fin);
    end else begin
      add_unit(16'($urandom_range(0, 65535)), fin);
    end
  endtask

  // Waits until every unit has been accepted and every byte has come out,
  // then lets the encoder settle in case the last unit produced nothing.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (unit_q.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic select_charset(input logic [1:0] mode);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    charset = mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int phase_end;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // UTF-8: length boundaries, surrogate pairs at both ends of the range,
    // a broken pair with the rest of its string swallowed, a high half as
    // the last unit, a lone low half, and two high halves in a row.
    select_charset(MODE_UTF8);
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(HIGH_FIRST, 1'b0);
    add_unit(LOW_FIRST, 1'b0);
    add_unit(HIGH_LAST, 1'b0);
    add_unit(LOW_LAST, 1'b1);
    add_unit(16'hD801, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'h1234, 1'b0);
    add_unit(16'h0042, 1'b1);
    add_unit(16'hDA00, 1'b1);
    add_unit(16'hDC05, 1'b1);
    add_unit(HIGH_FIRST, 1'b0);
    add_unit(HIGH_FIRST, 1'b1);
    // Leave a high half pending across the switch to ASCII.
    add_unit(HIGH_FIRST, 1'b0);

    select_charset(MODE_ASCII);
    add_unit(16'h0041, 1'b1);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0000, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'h0041, 1'b1);

    select_charset(MODE_LATIN1);
    add_unit(16'h00FF, 1'b0);
    add_unit(16'h0100, 1'b1);
    add_unit(16'h0080, 1'b1);

    select_charset(MODE_SPARE);
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hDE00, 1'b0);
    add_unit(16'h0800, 1'b1);

    // Random strings, cycling through all four charset codes.
    phase = 0;
    queued_units = 0;
    while (queued_units < RANDOM_UNITS) begin
      select_charset(phase[1:0]);
      phase_end = queued_units + PHASE_UNITS;
      while (queued_units < phase_end) begin
        if ($urandom_range(0, 19) == 0)
          len = $urandom_range(20, 40);
        else
          len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          add_char(phase[1:0], i == len - 1);
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Far beyond the slowest correct run, long holds included.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/u16enc_pkg.sv
design/u16enc_front.sv
design/u16enc_fifo.sv
design/u16enc_back.sv
design/utf16_to_charset_encoder.sv
verif/utf16_to_charset_encoder_tb.sv
